// File: hdl/hgns_pkg.sv
// ----------------------------------------------------------------------------
// Hash grid neighbor search package
// Shared widths, command codes and configuration register indexes.
// ----------------------------------------------------------------------------
package hgns_pkg;

  localparam int COORD_W = 32;
  localparam int RAD_W   = 31;
  localparam int RES_W   = 7;
  localparam int KEY_W   = 21;
  localparam int CFG_W   = 2;

  typedef enum logic [1:0] {
    CMD_CLEAR     = 2'd0,
    CMD_INSERT    = 2'd1,
    CMD_QUERY_ALL = 2'd2,
    CMD_QUERY_ANY = 2'd3
  } cmd_e;

  localparam logic [CFG_W-1:0] CFG_SPACING = 2'd0;
  localparam logic [CFG_W-1:0] CFG_RES_X   = 2'd1;
  localparam logic [CFG_W-1:0] CFG_RES_Y   = 2'd2;
  localparam logic [CFG_W-1:0] CFG_RES_Z   = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

endpackage

// File: hdl/hgns_in_if.sv
// ----------------------------------------------------------------------------
// Hash grid neighbor search command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface hgns_in_if import hgns_pkg::*; ();
  logic               valid;
  logic               ready;
  cmd_e               cmd;
  coord_t             pos_x;
  coord_t             pos_y;
  coord_t             pos_z;
  logic [RAD_W-1:0]   radius;

  modport source (output valid, cmd, pos_x, pos_y, pos_z, radius, input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, pos_z, radius, output ready);
endinterface

// File: hdl/hgns_out_if.sv
// ----------------------------------------------------------------------------
// Hash grid neighbor search result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface hgns_out_if import hgns_pkg::*; #(parameter int IDX_W = 10) ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   point_index;
  coord_t             found_x;
  coord_t             found_y;
  coord_t             found_z;
  logic               found;
  logic               accepted;
  logic               last;

  modport source (output valid, point_index, found_x, found_y, found_z, found, accepted,
                  last, input ready);
  modport sink   (input valid, point_index, found_x, found_y, found_z, found, accepted,
                  last, output ready);
endinterface

// File: hdl/hgns_ram.sv
// ----------------------------------------------------------------------------
// Hash grid neighbor search RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hgns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: hdl/hash_grid_neighbor_search.sv
// ----------------------------------------------------------------------------
// Hash grid neighbor search
// 3D points in a hashed grid with insert, clear and radius queries.
// Insert runs the floor divider, the wrap unit, the key pipeline and the bucket
// fill read; a query runs the same steps and then visits each cell and each
// bucket entry in turn. One item is worked on at a time.
// Reset and clear run a pass over every entry of the bucket fill RAM
// with no item accepted; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module hash_grid_neighbor_search import hgns_pkg::*; #(
  parameter int MAX_POINTS   = 1024,
  parameter int NUM_BUCKETS  = 4096,
  parameter int BUCKET_DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_idx_i,
  input  logic [RAD_W-1:0]  cfg_data_i,
  hgns_in_if.sink           in_i,
  hgns_out_if.source        out_o
);

  localparam int IDX_W   = $clog2(MAX_POINTS);
  localparam int PC_W    = IDX_W + 1;
  localparam int FILL_AW = $clog2(NUM_BUCKETS);
  localparam int FILL_W  = $clog2(BUCKET_DEPTH + 1);
  localparam int SLOT_AW = $clog2(NUM_BUCKETS * BUCKET_DEPTH);
  localparam int RECIP   = (2 ** KEY_W) / NUM_BUCKETS;
  localparam int PT_W    = 3 * COORD_W;

  localparam logic [4:0] S_SWEEP  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DIV    = 5'd2;
  localparam logic [4:0] S_FIX    = 5'd3;
  localparam logic [4:0] S_MOD    = 5'd4;
  localparam logic [4:0] S_WRAP   = 5'd5;
  localparam logic [4:0] S_KEY1   = 5'd6;
  localparam logic [4:0] S_KEY2   = 5'd7;
  localparam logic [4:0] S_KEY3   = 5'd8;
  localparam logic [4:0] S_KEY4   = 5'd9;
  localparam logic [4:0] S_KEY5   = 5'd10;
  localparam logic [4:0] S_FILLRD = 5'd11;
  localparam logic [4:0] S_FILLWT = 5'd12;
  localparam logic [4:0] S_INS    = 5'd13;
  localparam logic [4:0] S_SLOT   = 5'd14;
  localparam logic [4:0] S_SLOTWT = 5'd15;
  localparam logic [4:0] S_PTWT   = 5'd16;
  localparam logic [4:0] S_MUL    = 5'd17;
  localparam logic [4:0] S_CMP    = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  logic [4:0]          state_q, state_d;
  logic [5:0]          cnt_q;
  logic [FILL_AW-1:0]  sweep_q;
  logic [PC_W-1:0]     pc_q;
  logic [2:0]          nb_q;
  logic [FILL_W-1:0]   j_q;
  logic                pend_v_q;
  logic                any_q;

  logic [RAD_W-1:0]    spacing_q;
  logic [RES_W-1:0]    res_q [3];

  cmd_e                cmd_q;
  coord_t              pos_q [3];
  logic [RAD_W-1:0]    rad_q;
  logic [2*RAD_W-1:0]  r2_q;
  logic                neg_q [3];
  logic [COORD_W-1:0]  dvd_q [3];
  logic [COORD_W-1:0]  rem_q [3];
  logic                up_q  [3];
  logic [COORD_W:0]    mm_q  [3];
  logic [RES_W-1:0]    mrem_q [3];
  logic [RES_W-1:0]    w0_q  [3];
  logic [RES_W-1:0]    w1_q  [3];
  logic [13:0]         t1_q;
  logic [KEY_W-1:0]    t2_q;
  logic [2*KEY_W-1:0]  prod_q;
  logic [KEY_W-1:0]    qn_q;
  logic [FILL_AW-1:0]  key_q;
  logic [FILL_W-1:0]   fill_q;
  logic [IDX_W-1:0]    idx_q;
  logic [PT_W-1:0]     pt_q;
  logic [RAD_W-1:0]    d_q   [3];
  logic                close_q;
  logic [2*RAD_W-1:0]  sq_q  [3];
  logic [IDX_W-1:0]    pend_idx_q;
  logic [PT_W-1:0]     pend_pt_q;

  logic                out_valid_q;
  logic [IDX_W-1:0]    out_idx_q;
  logic [PT_W-1:0]     out_pt_q;
  logic                out_found_q, out_acc_q, out_last_q;

  logic [RAD_W-1:0]    sp_eff;
  logic [RES_W-1:0]    r_eff [3];
  logic [COORD_W-1:0]  trial [3];
  logic                ge    [3];
  logic [RES_W:0]      mtrial [3];
  logic                mge   [3];
  logic [RAD_W-1:0]    frem  [3];
  logic                rnz   [3];
  logic [RES_W-1:0]    w0    [3];
  logic [RES_W-1:0]    wsel  [3];
  logic [COORD_W:0]    diff  [3];
  logic [COORD_W:0]    adiff [3];
  logic [KEY_W-1:0]    krem;
  logic [2*RAD_W+1:0]  dsum;
  logic                hit;
  logic                slot_free;
  logic                full;

  logic                push;
  logic [IDX_W-1:0]    push_idx;
  logic [PT_W-1:0]     push_pt;
  logic                push_found, push_acc, push_last;

  logic                fill_we;
  logic [FILL_AW-1:0]  fill_waddr;
  logic [FILL_W-1:0]   fill_wdata, fill_rd;
  logic                ins_we;
  logic [SLOT_AW-1:0]  slot_addr;
  logic [IDX_W-1:0]    slot_rd;
  logic [PT_W-1:0]     store_rd;

  hgns_ram #(.WIDTH(FILL_W), .DEPTH(NUM_BUCKETS)) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .raddr_i (key_q),
    .rdata_o (fill_rd)
  );

  hgns_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BUCKETS * BUCKET_DEPTH)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ins_we),
    .waddr_i (slot_addr),
    .wdata_i (pc_q[IDX_W-1:0]),
    .raddr_i (slot_addr),
    .rdata_o (slot_rd)
  );

  hgns_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (ins_we),
    .waddr_i (pc_q[IDX_W-1:0]),
    .wdata_i ({pos_q[2], pos_q[1], pos_q[0]}),
    .raddr_i (slot_rd),
    .rdata_o (store_rd)
  );

  assign slot_addr = SLOT_AW'(key_q) * SLOT_AW'(BUCKET_DEPTH) + SLOT_AW'(j_q);
  assign sp_eff    = (spacing_q == '0) ? RAD_W'(1) : spacing_q;
  assign slot_free = !out_valid_q || out_o.ready;
  assign full      = (pc_q >= PC_W'(MAX_POINTS)) || (fill_q >= FILL_W'(BUCKET_DEPTH));
  assign krem      = t2_q - qn_q;
  assign dsum      = (2*RAD_W+2)'(sq_q[0]) + (2*RAD_W+2)'(sq_q[1]) + (2*RAD_W+2)'(sq_q[2]);
  assign hit       = close_q && (dsum <= (2*RAD_W+2)'(r2_q));

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      r_eff[a]  = (res_q[a] == '0) ? RES_W'(1) : res_q[a];
      trial[a]  = {rem_q[a][COORD_W-2:0], dvd_q[a][COORD_W-1]};
      ge[a]     = trial[a] >= {1'b0, sp_eff};
      mtrial[a] = {mrem_q[a], mm_q[a][COORD_W]};
      mge[a]    = mtrial[a] >= {1'b0, r_eff[a]};
      rnz[a]    = rem_q[a] != '0;
      frem[a]   = (neg_q[a] && rnz[a]) ? sp_eff - rem_q[a][RAD_W-1:0] : rem_q[a][RAD_W-1:0];
      w0[a]     = (neg_q[a] && mrem_q[a] != '0) ? r_eff[a] - mrem_q[a] : mrem_q[a];
      wsel[a]   = nb_q[2-a] ? w1_q[a] : w0_q[a];
      diff[a]   = {pos_q[a][COORD_W-1], pos_q[a]} -
                  {store_rd[a*COORD_W+COORD_W-1], store_rd[a*COORD_W +: COORD_W]};
      adiff[a]  = diff[a][COORD_W] ? -diff[a] : diff[a];
    end
  end

  always_comb begin
    state_d    = state_q;
    push       = 1'b0;
    push_idx   = '0;
    push_pt    = '0;
    push_found = 1'b0;
    push_acc   = 1'b0;
    push_last  = 1'b0;
    fill_we    = 1'b0;
    fill_waddr = key_q;
    fill_wdata = fill_q + FILL_W'(1);
    ins_we     = 1'b0;
    case (state_q)
      S_SWEEP: begin
        fill_we    = 1'b1;
        fill_waddr = sweep_q;
        fill_wdata = '0;
        if (sweep_q == FILL_AW'(NUM_BUCKETS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_i.valid) state_d = (in_i.cmd == CMD_CLEAR) ? S_SWEEP : S_DIV;
      end
      S_DIV:    if (cnt_q == 6'd31) state_d = S_FIX;
      S_FIX:    state_d = S_MOD;
      S_MOD:    if (cnt_q == 6'd32) state_d = S_WRAP;
      S_WRAP:   state_d = S_KEY1;
      S_KEY1:   state_d = S_KEY2;
      S_KEY2:   state_d = S_KEY3;
      S_KEY3:   state_d = S_KEY4;
      S_KEY4:   state_d = S_KEY5;
      S_KEY5:   state_d = S_FILLRD;
      S_FILLRD: state_d = S_FILLWT;
      S_FILLWT: state_d = (cmd_q == CMD_INSERT) ? S_INS : S_SLOT;
      S_INS: begin
        if (slot_free) begin
          push       = 1'b1;
          push_idx   = full ? '0 : pc_q[IDX_W-1:0];
          push_pt    = {pos_q[2], pos_q[1], pos_q[0]};
          push_acc   = !full;
          push_last  = 1'b1;
          fill_we    = !full;
          ins_we     = !full;
          state_d    = S_IDLE;
        end
      end
      S_SLOT: begin
        if (j_q >= fill_q) state_d = (nb_q == 3'd7) ? S_DONE : S_KEY1;
        else               state_d = S_SLOTWT;
      end
      S_SLOTWT: state_d = S_PTWT;
      S_PTWT:   state_d = S_MUL;
      S_MUL:    state_d = S_CMP;
      S_CMP: begin
        if (hit && cmd_q == CMD_QUERY_ALL && pend_v_q) begin
          if (slot_free) begin
            push       = 1'b1;
            push_idx   = pend_idx_q;
            push_pt    = pend_pt_q;
            push_found = 1'b1;
            state_d    = S_SLOT;
          end
        end else begin
          state_d = S_SLOT;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          if (cmd_q == CMD_QUERY_ANY) begin
            push_found = any_q;
          end else if (pend_v_q) begin
            push_idx   = pend_idx_q;
            push_pt    = pend_pt_q;
            push_found = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      cnt_q       <= '0;
      sweep_q     <= '0;
      pc_q        <= '0;
      nb_q        <= '0;
      j_q         <= '0;
      pend_v_q    <= 1'b0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
      spacing_q   <= RAD_W'(65536);
      res_q[0]    <= RES_W'(16);
      res_q[1]    <= RES_W'(16);
      res_q[2]    <= RES_W'(16);
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SPACING: spacing_q <= cfg_data_i;
          CFG_RES_X:   res_q[0]  <= cfg_data_i[RES_W-1:0];
          CFG_RES_Y:   res_q[1]  <= cfg_data_i[RES_W-1:0];
          CFG_RES_Z:   res_q[2]  <= cfg_data_i[RES_W-1:0];
          default:     spacing_q <= spacing_q;
        endcase
      end
      if (state_q == S_SWEEP) sweep_q <= sweep_q + FILL_AW'(1);
      if (state_q == S_IDLE && in_i.valid) begin
        cnt_q   <= '0;
        nb_q    <= '0;
        sweep_q <= '0;
        if (in_i.cmd == CMD_CLEAR) pc_q <= '0;
      end
      if (state_q == S_DIV) cnt_q <= (cnt_q == 6'd31) ? '0 : cnt_q + 6'd1;
      if (state_q == S_MOD) cnt_q <= cnt_q + 6'd1;
      if (state_q == S_FILLWT) j_q <= (cmd_q == CMD_INSERT) ? fill_rd : '0;
      if (state_q == S_INS && slot_free && !full) pc_q <= pc_q + PC_W'(1);
      if (state_q == S_SLOT && j_q >= fill_q) nb_q <= nb_q + 3'd1;
      if (state_q == S_CMP && state_d == S_SLOT) begin
        j_q <= j_q + FILL_W'(1);
        if (hit) begin
          any_q <= 1'b1;
          if (cmd_q == CMD_QUERY_ALL) pend_v_q <= 1'b1;
        end
      end
      if (state_q == S_DONE && slot_free) begin
        pend_v_q <= 1'b0;
        any_q    <= 1'b0;
      end
      if (push)              out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      cmd_q    <= in_i.cmd;
      pos_q[0] <= in_i.pos_x;
      pos_q[1] <= in_i.pos_y;
      pos_q[2] <= in_i.pos_z;
      rad_q    <= in_i.radius;
      neg_q[0] <= in_i.pos_x[COORD_W-1];
      neg_q[1] <= in_i.pos_y[COORD_W-1];
      neg_q[2] <= in_i.pos_z[COORD_W-1];
      dvd_q[0] <= in_i.pos_x[COORD_W-1] ? -in_i.pos_x : in_i.pos_x;
      dvd_q[1] <= in_i.pos_y[COORD_W-1] ? -in_i.pos_y : in_i.pos_y;
      dvd_q[2] <= in_i.pos_z[COORD_W-1] ? -in_i.pos_z : in_i.pos_z;
      for (int a = 0; a < 3; a++) rem_q[a] <= '0;
    end
    for (int a = 0; a < 3; a++) begin
      if (state_q == S_DIV) begin
        rem_q[a] <= ge[a] ? trial[a] - {1'b0, sp_eff} : trial[a];
        dvd_q[a] <= {dvd_q[a][COORD_W-2:0], ge[a]};
      end
      if (state_q == S_FIX) begin
        up_q[a]   <= {frem[a], 1'b0} >= {1'b0, sp_eff};
        mm_q[a]   <= {1'b0, dvd_q[a]} + (COORD_W+1)'(neg_q[a] && rnz[a]);
        mrem_q[a] <= '0;
      end
      if (state_q == S_MOD) begin
        mrem_q[a] <= mge[a] ? RES_W'(mtrial[a] - {1'b0, r_eff[a]}) : mtrial[a][RES_W-1:0];
        mm_q[a]   <= {mm_q[a][COORD_W-1:0], 1'b0};
      end
      if (state_q == S_WRAP) begin
        w0_q[a] <= w0[a];
        if (up_q[a]) w1_q[a] <= (w0[a] + RES_W'(1) == r_eff[a]) ? '0 : w0[a] + RES_W'(1);
        else         w1_q[a] <= (w0[a] == '0) ? r_eff[a] - RES_W'(1) : w0[a] - RES_W'(1);
      end
      if (state_q == S_PTWT) d_q[a] <= adiff[a][RAD_W-1:0];
      if (state_q == S_MUL)  sq_q[a] <= d_q[a] * d_q[a];
    end
    if (state_q == S_FIX)  r2_q <= rad_q * rad_q;
    if (state_q == S_KEY1) t1_q <= 14'(wsel[2]) * 14'(r_eff[1]) + 14'(wsel[1]);
    if (state_q == S_KEY2) t2_q <= KEY_W'(t1_q) * KEY_W'(r_eff[0]) + KEY_W'(wsel[0]);
    if (state_q == S_KEY3) prod_q <= t2_q * KEY_W'(RECIP);
    if (state_q == S_KEY4) qn_q <= KEY_W'(prod_q[2*KEY_W-1:KEY_W] * KEY_W'(NUM_BUCKETS));
    if (state_q == S_KEY5) begin
      key_q <= (krem >= KEY_W'(NUM_BUCKETS)) ? FILL_AW'(krem - KEY_W'(NUM_BUCKETS))
                                             : FILL_AW'(krem);
    end
    if (state_q == S_FILLWT) fill_q <= fill_rd;
    if (state_q == S_SLOTWT) idx_q <= slot_rd;
    if (state_q == S_PTWT) begin
      pt_q    <= store_rd;
      close_q <= (adiff[0] <= (COORD_W+1)'(rad_q)) && (adiff[1] <= (COORD_W+1)'(rad_q)) &&
                 (adiff[2] <= (COORD_W+1)'(rad_q));
    end
    if (state_q == S_CMP && state_d == S_SLOT && hit) begin
      pend_idx_q <= idx_q;
      pend_pt_q  <= pt_q;
    end
    if (push) begin
      out_idx_q   <= push_idx;
      out_pt_q    <= push_pt;
      out_found_q <= push_found;
      out_acc_q   <= push_acc;
      out_last_q  <= push_last;
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.point_index = out_idx_q;
  assign out_o.found_x     = out_pt_q[0 +: COORD_W];
  assign out_o.found_y     = out_pt_q[COORD_W +: COORD_W];
  assign out_o.found_z     = out_pt_q[2*COORD_W +: COORD_W];
  assign out_o.found       = out_found_q;
  assign out_o.accepted    = out_acc_q;
  assign out_o.last        = out_last_q;

  a_pc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PC_W'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_we |-> fill_wdata <= FILL_W'(BUCKET_DEPTH))
    else $error("bucket fill beyond bucket depth");

  a_found_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.found && out_o.accepted))
    else $error("result both found and accepted");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> slot_free)
    else $error("result pushed over a waiting item");

  a_clear_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.cmd == CMD_CLEAR) |=> state_q == S_SWEEP && pc_q == '0)
    else $error("clear did not start the sweep");

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Hash grid neighbor search testbench
// Drives clear, insert and radius query items under random idling on both
// channels. Predicts every result from a local copy of the point store, the
// buckets and the configuration, and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_top import hgns_pkg::*; ();

  localparam int NPTS      = 1024;
  localparam int NBKT      = 4096;
  localparam int BDEPTH    = 8;
  localparam int MAX_HITS  = 64;
  localparam int IDLE_LIM  = 30000;
  localparam int CLEAR_GAP = 4300;
  localparam int HOLD_LEN  = 2000;

  typedef struct {
    logic [9:0] idx;
    coord_t     x;
    coord_t     y;
    coord_t     z;
    logic       found;
    logic       accepted;
    logic       last;
  } hit_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_W-1:0] cfg_idx_i;
  logic [RAD_W-1:0] cfg_data_i;

  hgns_in_if  in_ch ();
  hgns_out_if out_ch ();

  hash_grid_neighbor_search dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  coord_t      pt_x [NPTS];
  coord_t      pt_y [NPTS];
  coord_t      pt_z [NPTS];
  logic [9:0]  slot_idx [NBKT*BDEPTH];
  int unsigned slot_fill [NBKT];
  int unsigned pt_count;
  logic [RAD_W-1:0] cell_edge;
  logic [RES_W-1:0] res_x, res_y, res_z;

  hit_t expected_hits [$];
  int   fail_cnt;
  int   items_sent;
  int   results_seen;
  int   idle_cycles;
  bit   no_idle;
  bit   hold_off_req;
  cmd_e last_cmd;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint edge_len();
    return (cell_edge == 0) ? 64'sd1 : longint'({1'b0, cell_edge});
  endfunction

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint wrap_cell(longint c, logic [RES_W-1:0] r);
    longint rr, w;
    rr = (r == 0) ? 64'sd1 : longint'({1'b0, r});
    w = c % rr;
    if (w < 0) w += rr;
    return w;
  endfunction

  function automatic int unsigned cell_key(longint cx, longint cy, longint cz);
    longint ry, rx, k;
    ry = (res_y == 0) ? 64'sd1 : longint'({1'b0, res_y});
    rx = (res_x == 0) ? 64'sd1 : longint'({1'b0, res_x});
    k = (wrap_cell(cz, res_z) * ry + wrap_cell(cy, res_y)) * rx + wrap_cell(cx, res_x);
    return int'(k % NBKT);
  endfunction

  function automatic longint side_step(longint p, longint c);
    return (2 * (p - c * edge_len()) >= edge_len()) ? 64'sd1 : -64'sd1;
  endfunction

  function automatic longint abs_diff(longint a, longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic void predict_grid_op(cmd_e c, coord_t x, coord_t y, coord_t z,
                                          logic [RAD_W-1:0] rad);
    longint px, py, pz, cx, cy, cz, sx, sy, sz, dx, dy, dz, rl;
    int unsigned key, fill;
    logic [9:0] idx;
    logic [65:0] r2, d2;
    hit_t h, m, hits [$];
    bit any;
    px = longint'(x);
    py = longint'(y);
    pz = longint'(z);
    cx = floor_div(px, edge_len());
    cy = floor_div(py, edge_len());
    cz = floor_div(pz, edge_len());
    h = '{idx: '0, x: '0, y: '0, z: '0, found: 1'b0, accepted: 1'b0, last: 1'b1};
    case (c)
      CMD_CLEAR: begin
        foreach (slot_fill[k]) slot_fill[k] = 0;
        pt_count = 0;
      end
      CMD_INSERT: begin
        key = cell_key(cx, cy, cz);
        h.x = x;
        h.y = y;
        h.z = z;
        if (pt_count < NPTS && slot_fill[key] < BDEPTH) begin
          pt_x[pt_count] = x;
          pt_y[pt_count] = y;
          pt_z[pt_count] = z;
          slot_idx[key*BDEPTH + slot_fill[key]] = pt_count[9:0];
          slot_fill[key]++;
          h.idx = pt_count[9:0];
          h.accepted = 1'b1;
          pt_count++;
        end
        expected_hits = {expected_hits, h};
      end
      default: begin
        sx = side_step(px, cx);
        sy = side_step(py, cy);
        sz = side_step(pz, cz);
        rl = longint'({1'b0, rad});
        r2 = 66'(rl) * 66'(rl);
        any = 1'b0;
        for (int i = 0; i < 8; i++) begin
          key = cell_key(cx + ((i & 4) ? sx : 0), cy + ((i & 2) ? sy : 0),
                         cz + ((i & 1) ? sz : 0));
          fill = (slot_fill[key] > BDEPTH) ? BDEPTH : slot_fill[key];
          for (int j = 0; j < fill; j++) begin
            idx = slot_idx[key*BDEPTH + j];
            dx = abs_diff(longint'(pt_x[idx]), px);
            dy = abs_diff(longint'(pt_y[idx]), py);
            dz = abs_diff(longint'(pt_z[idx]), pz);
            if (dx > rl || dy > rl || dz > rl) continue;
            d2 = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy) + 66'(dz) * 66'(dz);
            if (d2 > r2) continue;
            any = 1'b1;
            if (c == CMD_QUERY_ALL && hits.size() < MAX_HITS) begin
              m = '{idx: idx, x: pt_x[idx], y: pt_y[idx], z: pt_z[idx],
                    found: 1'b1, accepted: 1'b0, last: 1'b0};
              hits = {hits, m};
            end
          end
        end
        if (c == CMD_QUERY_ANY) begin
          h.found = any;
          expected_hits = {expected_hits, h};
        end else if (hits.size() == 0) begin
          expected_hits = {expected_hits, h};
        end else begin
          hits[hits.size()-1].last = 1'b1;
          expected_hits = {expected_hits, hits};
        end
      end
    endcase
  endfunction

  task automatic send_item(cmd_e c, coord_t x, coord_t y, coord_t z,
                           logic [RAD_W-1:0] rad);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= c;
    in_ch.pos_x  <= x;
    in_ch.pos_y  <= y;
    in_ch.pos_z  <= z;
    in_ch.radius <= rad;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_grid_op(c, x, y, z, rad);
    last_cmd = c;
    items_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_hits.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_W-1:0] idx, logic [RAD_W-1:0] data);
    drain();
    repeat ((last_cmd == CMD_CLEAR) ? CLEAR_GAP : 100) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SPACING: cell_edge = data;
      CFG_RES_X:   res_x = data[RES_W-1:0];
      CFG_RES_Y:   res_y = data[RES_W-1:0];
      default:     res_z = data[RES_W-1:0];
    endcase
    last_cmd = CMD_INSERT;
  endtask

  task automatic set_grid(logic [RAD_W-1:0] sp, logic [RES_W-1:0] rx,
                          logic [RES_W-1:0] ry, logic [RES_W-1:0] rz);
    write_reg(CFG_SPACING, sp);
    write_reg(CFG_RES_X, RAD_W'(rx));
    write_reg(CFG_RES_Y, RAD_W'(ry));
    write_reg(CFG_RES_Z, RAD_W'(rz));
  endtask

  function automatic coord_t near_coord(longint span);
    return coord_t'(longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic random_traffic(int n);
    longint span;
    int r;
    cmd_e c;
    span = edge_len() * 2;
    if (span > 64'sd1 << 29) span = 64'sd1 << 29;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      c = (r < 40) ? CMD_INSERT : (r < 65) ? CMD_QUERY_ALL : (r < 85) ? CMD_QUERY_ANY :
          (r < 88) ? CMD_CLEAR : cmd_e'($urandom_range(0, 3));
      if (r < 88)
        send_item(c, near_coord(span), near_coord(span), near_coord(span),
                  RAD_W'($urandom_range(0, int'(span))));
      else
        send_item(c, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  RAD_W'($urandom));
    end
  endtask

  task automatic test_directed();
    coord_t mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    send_item(CMD_INSERT, '0, '0, '0, '0);
    send_item(CMD_INSERT, mx, mx, mx, '0);
    send_item(CMD_INSERT, mn, mn, mn, '1);
    send_item(CMD_INSERT, -32'sd1, -32'sd1, -32'sd1, '0);
    send_item(CMD_INSERT, 32'sh8000, 32'sh7fff, 32'shffff, '0);
    send_item(CMD_INSERT, 32'sh18000, -32'sh8000, 32'sh10000, '0);
    send_item(CMD_QUERY_ALL, '0, '0, '0, '0);
    send_item(CMD_QUERY_ALL, '0, '0, '0, 31'h7fffffff);
    send_item(CMD_QUERY_ALL, mx, mx, mx, '0);
    send_item(CMD_QUERY_ALL, mn, mn, mn, 31'h7fffffff);
    send_item(CMD_QUERY_ALL, 32'sh8000, 32'sh8000, 32'sh8000, 31'h10000);
    send_item(CMD_QUERY_ALL, 32'sh7fff, 32'sh7fff, 32'sh7fff, 31'h10000);
    send_item(CMD_QUERY_ALL, 32'sh50000, 32'sh50000, 32'sh50000, 31'h100);
    send_item(CMD_QUERY_ANY, '0, '0, '0, '0);
    send_item(CMD_QUERY_ANY, 32'sh50000, 32'sh50000, 32'sh50000, 31'h100);
    send_item(CMD_QUERY_ANY, -32'sd2, -32'sd2, -32'sd2, 31'd1);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    send_item(CMD_QUERY_ANY, '0, '0, '0, 31'h7fffffff);
  endtask

  task automatic test_bucket_full_and_wrap();
    set_grid(31'h10000, 7'd1, 7'd1, 7'd1);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    for (int i = 0; i < 9; i++)
      send_item(CMD_INSERT, coord_t'(32'sh18000 + i), 32'sh18000, 32'sh18000, '0);
    send_item(CMD_QUERY_ALL, 32'sh18000, 32'sh18000, 32'sh18000, 31'h7fffffff);
    send_item(CMD_QUERY_ANY, 32'sh18000, 32'sh18000, 32'sh18000, 31'd3);
    send_item(CMD_QUERY_ALL, 32'sh18000, 32'sh18000, 32'sh18000, 31'd3);
  endtask

  task automatic test_backpressure();
    hold_off_req = 1'b1;
    for (int i = 0; i < 12; i++)
      send_item(i[0] ? CMD_QUERY_ALL : CMD_INSERT, near_coord(64'sd4),
                near_coord(64'sd4), near_coord(64'sd4), 31'd6);
    drain();
    random_traffic(10);
  endtask

  task automatic test_config_sweep();
    set_grid(31'h7fffffff, 7'd64, 7'd64, 7'd64);
    random_traffic(20);
    set_grid(31'd0, 7'd0, 7'd0, 7'd0);
    random_traffic(15);
    set_grid(31'h4000, 7'd3, 7'd64, 7'd1);
    random_traffic(20);
    set_grid(31'h10000, 7'd16, 7'd16, 7'd16);
    no_idle = 1'b1;
    random_traffic(15);
    no_idle = 1'b0;
    random_traffic(25);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      int gap;
      gap = pick_gap();
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
      end else if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    hit_t h;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_hits.size() == 0) begin
        $error("result with no item pending: point_index %0d", out_ch.point_index);
        fail_cnt++;
      end else begin
        h = expected_hits.pop_front();
        check_field("point_index", h.idx, out_ch.point_index);
        check_field("found_x", h.x, out_ch.found_x);
        check_field("found_y", h.y, out_ch.found_y);
        check_field("found_z", h.z, out_ch.found_z);
        check_field("found", h.found, out_ch.found);
        check_field("accepted", h.accepted, out_ch.accepted);
        check_field("last", h.last, out_ch.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIM) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_SPACING;
    cfg_data_i   <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= CMD_CLEAR;
    in_ch.pos_x  <= '0;
    in_ch.pos_y  <= '0;
    in_ch.pos_z  <= '0;
    in_ch.radius <= '0;
    fail_cnt = 0;
    items_sent = 0;
    results_seen = 0;
    no_idle = 1'b0;
    hold_off_req = 1'b0;
    last_cmd = CMD_CLEAR;
    cell_edge = 31'h10000;
    res_x = 7'd16;
    res_y = 7'd16;
    res_z = 7'd16;
    pt_count = 0;
    foreach (slot_fill[k]) slot_fill[k] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_backpressure();
    test_bucket_full_and_wrap();
    test_config_sweep();

    drain();
    repeat (300) @(posedge clk_i);
    $display("Sent %0d items (clear, insert, query all, query any) over several grid setups,",
             items_sent);
    $display("checked %0d results incl. full bucket, wrapped cells and a long output stall.",
             results_seen);
    if (fail_cnt == 0 && expected_hits.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/hgns_pkg.sv
hdl/hgns_in_if.sv
hdl/hgns_out_if.sv
hdl/hgns_ram.sv
hdl/hash_grid_neighbor_search.sv
dv/tb_top.sv
